/* design/cp2u8_pkg.sv */
// Shared types, constants and functions for the code page to UTF-8 encoder.
// No dependencies; every other design file refers to this package by scoped name.
package cp2u8_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int CP_W    = 31;
    localparam int LEN_W   = 3;
    localparam int MODE_W  = 2;

    // source_mode codes; the unused code falls back to raw
    localparam logic [MODE_W-1:0] MODE_RAW    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CP1251 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LATIN1 = 2'd2;

    // sequence lengths
    localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4 = 3'd4;
    localparam logic [LEN_W-1:0] LEN_5 = 3'd5;
    localparam logic [LEN_W-1:0] LEN_6 = 3'd6;

    localparam logic [7:0] CONT_PREFIX = 8'h80;

    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
    } t_item;

    // Windows-1251 bytes 0x80..0xFF; the low half maps to itself
    localparam logic [15:0] CP1251_HIGH [128] = '{
        16'd1026, 16'd1027, 16'd8218, 16'd1107, 16'd8222, 16'd8230, 16'd8224, 16'd8225,
        16'd8364, 16'd8240, 16'd1033, 16'd8249, 16'd1034, 16'd1036, 16'd1035, 16'd1039,
        16'd1106, 16'd8216, 16'd8217, 16'd8220, 16'd8221, 16'd8226, 16'd8211, 16'd8212,
        16'd8250, 16'd8482, 16'd1113, 16'd8250, 16'd1114, 16'd1116, 16'd1115, 16'd1119,
        16'd160,  16'd1038, 16'd1118, 16'd1032, 16'd164,  16'd1168, 16'd166,  16'd167,
        16'd1025, 16'd169,  16'd1028, 16'd171,  16'd172,  16'd173,  16'd174,  16'd1031,
        16'd176,  16'd177,  16'd1030, 16'd1110, 16'd1169, 16'd181,  16'd182,  16'd183,
        16'd1105, 16'd8470, 16'd1108, 16'd187,  16'd1112, 16'd1029, 16'd1109, 16'd1111,
        16'd1040, 16'd1041, 16'd1042, 16'd1043, 16'd1044, 16'd1045, 16'd1046, 16'd1047,
        16'd1048, 16'd1049, 16'd1050, 16'd1051, 16'd1052, 16'd1053, 16'd1054, 16'd1055,
        16'd1056, 16'd1057, 16'd1058, 16'd1059, 16'd1060, 16'd1061, 16'd1062, 16'd1063,
        16'd1064, 16'd1065, 16'd1066, 16'd1067, 16'd1068, 16'd1069, 16'd1070, 16'd1071,
        16'd1072, 16'd1073, 16'd1074, 16'd1075, 16'd1076, 16'd1077, 16'd1078, 16'd1079,
        16'd1080, 16'd1081, 16'd1082, 16'd1083, 16'd1084, 16'd1085, 16'd1086, 16'd1087,
        16'd1088, 16'd1089, 16'd1090, 16'd1091, 16'd1092, 16'd1093, 16'd1094, 16'd1095,
        16'd1096, 16'd1097, 16'd1098, 16'd1099, 16'd1100, 16'd1101, 16'd1102, 16'd1103
    };

    function automatic logic [LEN_W-1:0] seq_len(input logic [CP_W-1:0] cp);
        logic [LEN_W-1:0] len;
        if (cp < 31'h80)           len = LEN_1;
        else if (cp < 31'h800)     len = LEN_2;
        else if (cp < 31'h10000)   len = LEN_3;
        else if (cp < 31'h200000)  len = LEN_4;
        else if (cp < 31'h4000000) len = LEN_5;
        else                       len = LEN_6;
        return len;
    endfunction

    function automatic logic [7:0] lead_prefix(input logic [LEN_W-1:0] len);
        logic [7:0] p;
        case (len)
            LEN_2:   p = 8'hC0;
            LEN_3:   p = 8'hE0;
            LEN_4:   p = 8'hF0;
            LEN_5:   p = 8'hF8;
            LEN_6:   p = 8'hFC;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

endpackage

/* design/codepage_to_utf8_encoder.sv */
// Top level of the code page to UTF-8 encoder: front end, item queue, back end.
// Depends on cp2u8_pkg, cp2u8_front, cp2u8_queue and cp2u8_back.
//
//  channel  | ports                               | transfer
//  ---------+-------------------------------------+----------------------------------
//  input    | start, busy, i_symbol               | edge with start high, busy low
//  config   | i_cfg_we, i_cfg_wdata               | edge with i_cfg_we high
//  result   | o_strobe, o_out_byte, o_last_byte   | every edge ending a strobe cycle
//
// A symbol of n bytes (1 to 6) leaves the back end one output byte per cycle;
// the back end sets the sustained rate. With the queue empty, a symbol is
// pushed, popped into the back end, then its first byte is registered out.
// busy is high while the queue holds QUEUE_DEPTH items; the front end keeps
// accepting while the back end is still emitting. Reset clears the queue,
// the back end and the source mode (raw). The receiver cannot stall.
module codepage_to_utf8_encoder #(
    parameter int QUEUE_DEPTH = cp2u8_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [cp2u8_pkg::CP_W-1:0]   i_symbol,
    input  logic                         i_cfg_we,
    input  logic [cp2u8_pkg::MODE_W-1:0] i_cfg_wdata,
    output logic                         o_strobe,
    output logic [7:0]                   o_out_byte,
    output logic                         o_last_byte
);

    cp2u8_pkg::t_item front_item;
    cp2u8_pkg::t_item q_item;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic             accept;

    // classify in the transfer cycle, push straight into the queue
    assign accept = start && !q_full;
    assign busy   = q_full;

    cp2u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_symbol    (i_symbol),
        .o_item      (front_item)
    );

    cp2u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // drain one byte per cycle, pop the next item as the last byte leaves
    cp2u8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_strobe    (o_strobe),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

endmodule

/* design/cp2u8_front.sv */
// Front end: holds the source mode register, maps each symbol to a code point
// and sizes its UTF-8 sequence. Depends on cp2u8_pkg.
module cp2u8_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cp2u8_pkg::MODE_W-1:0] i_cfg_wdata,
    input  logic [cp2u8_pkg::CP_W-1:0]  i_symbol,
    output cp2u8_pkg::t_item            o_item
);

    logic [cp2u8_pkg::MODE_W-1:0] r_mode;
    logic [cp2u8_pkg::CP_W-1:0]   cp;
    logic [7:0]                   sym_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= cp2u8_pkg::MODE_RAW;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    assign sym_byte = i_symbol[7:0];

    always_comb begin
        case (r_mode)
            cp2u8_pkg::MODE_CP1251: begin
                if (sym_byte[7]) cp = cp2u8_pkg::CP_W'(cp2u8_pkg::CP1251_HIGH[sym_byte[6:0]]);
                else             cp = cp2u8_pkg::CP_W'(sym_byte);
            end
            cp2u8_pkg::MODE_LATIN1: cp = cp2u8_pkg::CP_W'(sym_byte);
            default:                cp = i_symbol;
        endcase
    end

    assign o_item.cp  = cp;
    assign o_item.len = cp2u8_pkg::seq_len(cp);

endmodule

/* design/cp2u8_queue.sv */
// Small FIFO of classified items between the front and back ends.
// Depends on cp2u8_pkg for the item type.
module cp2u8_queue #(
    parameter int DEPTH = cp2u8_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cp2u8_pkg::t_item i_item,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output cp2u8_pkg::t_item o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cp2u8_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_cnt = r_cnt;
        if (do_push) n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        if (do_pop)  n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        if (do_push && !do_pop)      n_cnt = r_cnt + 1'b1;
        else if (do_pop && !do_push) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_item;
    end

endmodule

/* design/cp2u8_back.sv */
// Back end: unpacks one queued code point into its UTF-8 bytes, one per cycle,
// into registered outputs. Depends on cp2u8_pkg.
module cp2u8_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  cp2u8_pkg::t_item i_q_item,
    output logic             o_q_pop,
    output logic             o_strobe,
    output logic [7:0]       o_out_byte,
    output logic             o_last_byte
);

    logic                           r_act, n_act;
    logic                           r_first, n_first;
    logic [cp2u8_pkg::CP_W-1:0]     r_cp, n_cp;
    logic [cp2u8_pkg::LEN_W-1:0]    r_len, n_len;
    logic [cp2u8_pkg::LEN_W-1:0]    r_rem, n_rem;
    logic                           r_strobe;
    logic [7:0]                     r_byte, n_byte;
    logic                           r_last;
    logic [cp2u8_pkg::CP_W-1:0]     shifted;

    // select the 6-bit group for the byte in flight
    always_comb begin
        case (r_rem)
            3'd0:    shifted = r_cp;
            3'd1:    shifted = r_cp >> 6;
            3'd2:    shifted = r_cp >> 12;
            3'd3:    shifted = r_cp >> 18;
            3'd4:    shifted = r_cp >> 24;
            3'd5:    shifted = r_cp >> 30;
            default: shifted = r_cp;
        endcase
    end

    always_comb begin
        if (r_first) n_byte = cp2u8_pkg::lead_prefix(r_len) | shifted[7:0];
        else         n_byte = cp2u8_pkg::CONT_PREFIX | {2'b00, shifted[5:0]};
    end

    // take the next item when idle or while the last byte goes out
    assign o_q_pop = i_q_valid && (!r_act || (r_rem == '0));

    always_comb begin
        n_act   = r_act;
        n_first = r_first;
        n_cp    = r_cp;
        n_len   = r_len;
        n_rem   = r_rem;
        if (o_q_pop) begin
            n_act   = 1'b1;
            n_first = 1'b1;
            n_cp    = i_q_item.cp;
            n_len   = i_q_item.len;
            n_rem   = i_q_item.len - 1'b1;
        end else if (r_act) begin
            n_first = 1'b0;
            if (r_rem == '0) n_act = 1'b0;
            else             n_rem = r_rem - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_act    <= n_act;
            r_strobe <= r_act;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_cp    <= n_cp;
        r_len   <= n_len;
        r_rem   <= n_rem;
        r_byte  <= n_byte;
        r_last  <= (r_rem == '0);
    end

    assign o_strobe    = r_strobe;
    assign o_out_byte  = r_byte;
    assign o_last_byte = r_last;

    // a sequence never breaks off before its last byte
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_byte) |=> o_strobe)
        else $error("byte sequence interrupted");

    // bytes after a non-final byte are continuation bytes
    a_cont_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_byte) |=> (o_out_byte[7:6] == 2'b10))
        else $error("continuation byte malformed");

    // a byte that opens a sequence is never a continuation byte
    a_lead_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !($past(o_strobe) && !$past(o_last_byte)))
            |-> (o_out_byte[7:6] != 2'b10))
        else $error("lead byte malformed");

endmodule

/* verif/utf8_stream_checker.sv */
// Checker for the code page to UTF-8 encoder: watches the symbol, mode and byte channels,
// predicts each symbol's byte sequence and compares every emitted byte in order.
// Depends on cp2u8_pkg for widths and source mode codes.
module utf8_stream_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic [cp2u8_pkg::CP_W-1:0]   i_symbol,
    input  logic                         i_cfg_we,
    input  logic [cp2u8_pkg::MODE_W-1:0] i_cfg_wdata,
    input  logic                         i_strobe,
    input  logic [7:0]                   i_out_byte,
    input  logic                         i_last_byte,
    output int                           o_error_count,
    output int                           o_pending,
    output int                           o_bytes_checked
);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_utf8_byte;

    // Windows-1251 upper half; bytes below 0x80 are ASCII
    localparam logic [15:0] CP1251_UPPER [128] = '{
        16'd1026, 16'd1027, 16'd8218, 16'd1107, 16'd8222, 16'd8230, 16'd8224, 16'd8225,
        16'd8364, 16'd8240, 16'd1033, 16'd8249, 16'd1034, 16'd1036, 16'd1035, 16'd1039,
        16'd1106, 16'd8216, 16'd8217, 16'd8220, 16'd8221, 16'd8226, 16'd8211, 16'd8212,
        16'd8250, 16'd8482, 16'd1113, 16'd8250, 16'd1114, 16'd1116, 16'd1115, 16'd1119,
        16'd160,  16'd1038, 16'd1118, 16'd1032, 16'd164,  16'd1168, 16'd166,  16'd167,
        16'd1025, 16'd169,  16'd1028, 16'd171,  16'd172,  16'd173,  16'd174,  16'd1031,
        16'd176,  16'd177,  16'd1030, 16'd1110, 16'd1169, 16'd181,  16'd182,  16'd183,
        16'd1105, 16'd8470, 16'd1108, 16'd187,  16'd1112, 16'd1029, 16'd1109, 16'd1111,
        16'd1040, 16'd1041, 16'd1042, 16'd1043, 16'd1044, 16'd1045, 16'd1046, 16'd1047,
        16'd1048, 16'd1049, 16'd1050, 16'd1051, 16'd1052, 16'd1053, 16'd1054, 16'd1055,
        16'd1056, 16'd1057, 16'd1058, 16'd1059, 16'd1060, 16'd1061, 16'd1062, 16'd1063,
        16'd1064, 16'd1065, 16'd1066, 16'd1067, 16'd1068, 16'd1069, 16'd1070, 16'd1071,
        16'd1072, 16'd1073, 16'd1074, 16'd1075, 16'd1076, 16'd1077, 16'd1078, 16'd1079,
        16'd1080, 16'd1081, 16'd1082, 16'd1083, 16'd1084, 16'd1085, 16'd1086, 16'd1087,
        16'd1088, 16'd1089, 16'd1090, 16'd1091, 16'd1092, 16'd1093, 16'd1094, 16'd1095,
        16'd1096, 16'd1097, 16'd1098, 16'd1099, 16'd1100, 16'd1101, 16'd1102, 16'd1103
    };

    logic [cp2u8_pkg::MODE_W-1:0] source_mode_q;
    t_utf8_byte                   expected_bytes [$];

    // Map the symbol to a code point and queue its UTF-8 bytes, lead byte first.
    task automatic predict_utf8(input logic [cp2u8_pkg::CP_W-1:0] sym,
                                input logic [cp2u8_pkg::MODE_W-1:0] mode);
        logic [30:0] cp;
        logic [30:0] part;
        logic [7:0]  lead;
        int          n;
        t_utf8_byte  eb;
        case (mode)
            cp2u8_pkg::MODE_CP1251:
                cp = sym[7] ? {15'd0, CP1251_UPPER[sym[6:0]]} : {23'd0, sym[7:0]};
            cp2u8_pkg::MODE_LATIN1: cp = {23'd0, sym[7:0]};
            default:                cp = sym;   // raw, and the spare code acts as raw
        endcase
        if (cp < 31'h80)           n = 1;
        else if (cp < 31'h800)     n = 2;
        else if (cp < 31'h10000)   n = 3;
        else if (cp < 31'h200000)  n = 4;
        else if (cp < 31'h4000000) n = 5;
        else                       n = 6;
        case (n)
            2:       lead = 8'hC0;
            3:       lead = 8'hE0;
            4:       lead = 8'hF0;
            5:       lead = 8'hF8;
            6:       lead = 8'hFC;
            default: lead = 8'h00;
        endcase
        for (int k = 0; k < n; k++) begin
            part = cp >> (6 * (n - 1 - k));
            if (k == 0) eb.value = lead | part[7:0];
            else        eb.value = 8'h80 | {2'b00, part[5:0]};
            eb.last = (k == n - 1);
            expected_bytes.push_back(eb);
        end
    endtask

    // Check output bytes before queuing new ones: a byte never belongs to a
    // symbol transferred at the same edge.
    always @(posedge i_clk) begin : monitor
        t_utf8_byte want;
        if (!i_rst_n) begin
            expected_bytes.delete();
            source_mode_q   = cp2u8_pkg::MODE_RAW;
            o_error_count   = 0;
            o_bytes_checked = 0;
        end else begin
            if ($isunknown(i_strobe)) begin
                $display("%0t: strobe unknown, expected 0 or 1, got %b", $time, i_strobe);
                o_error_count++;
            end else if (i_strobe) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: byte %02h last %0b emitted, expected none pending",
                             $time, i_out_byte, i_last_byte);
                    o_error_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out_byte !== want.value) begin
                        $display("%0t: out_byte expected %02h, got %02h",
                                 $time, want.value, i_out_byte);
                        o_error_count++;
                    end
                    if (i_last_byte !== want.last) begin
                        $display("%0t: last_byte expected %0b, got %0b",
                                 $time, want.last, i_last_byte);
                        o_error_count++;
                    end
                    o_bytes_checked++;
                end
            end
            if (i_start && !i_busy) predict_utf8(i_symbol, source_mode_q);
            if (i_cfg_we) source_mode_q = i_cfg_wdata;
        end
        o_pending = expected_bytes.size();
    end

endmodule

/* verif/tb_codepage_to_utf8_encoder.sv */
// Testbench top for the code page to UTF-8 encoder: clock, reset, symbol and mode stimulus,
// verdict. Depends on cp2u8_pkg, codepage_to_utf8_encoder and utf8_stream_checker.
module tb_codepage_to_utf8_encoder;

    // The spare mode code; the block treats it as raw.
    localparam logic [cp2u8_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_CHUNKS = 8;
    localparam int CHUNK_ITEMS   = 40;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [cp2u8_pkg::CP_W-1:0]   i_symbol;
    logic                         i_cfg_we;
    logic [cp2u8_pkg::MODE_W-1:0] i_cfg_wdata;
    logic                         o_strobe;
    logic [7:0]                   o_out_byte;
    logic                         o_last_byte;

    int error_count;
    int pending_bytes;
    int bytes_checked;
    int symbols_sent  = 0;
    int mode_writes   = 0;
    int cycle_count   = 0;
    int sender_idle_pct;

    codepage_to_utf8_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_symbol    (i_symbol),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    utf8_stream_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_symbol        (i_symbol),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_strobe        (o_strobe),
        .i_out_byte      (o_out_byte),
        .i_last_byte     (o_last_byte),
        .o_error_count   (error_count),
        .o_pending       (pending_bytes),
        .o_bytes_checked (bytes_checked)
    );

    always #2 i_clk = ~i_clk;

    // Drop the run if it hangs: covers a lost byte or a busy that never clears.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Entered and left at a falling edge. Idle the sender at random first,
    // then hold start high until a cycle with busy low; busy only moves at the
    // rising edge, so its value at the falling edge decides the transfer.
    // Leave start high on return so back-to-back symbols go out with no gap between them.
    task automatic send_symbol(input logic [cp2u8_pkg::CP_W-1:0] sym);
        while ($urandom_range(99) < sender_idle_pct) begin
            start    <= 1'b0;
            i_symbol <= cp2u8_pkg::CP_W'($urandom);    // noise on the bus while idle
            @(negedge i_clk);
        end
        start    <= 1'b1;
        i_symbol <= sym;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        symbols_sent++;
    endtask

    // Stop sending, wait for every predicted byte, then let the pipeline settle.
    task automatic drain;
        start <= 1'b0;
        while (pending_bytes != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Change the source mode only with the block idle.
    task automatic write_mode(input logic [cp2u8_pkg::MODE_W-1:0] mode);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        mode_writes++;
    endtask

    function automatic logic [cp2u8_pkg::MODE_W-1:0] chunk_mode(input int chunk);
        case (chunk)
            0:       return cp2u8_pkg::MODE_CP1251;
            1:       return cp2u8_pkg::MODE_LATIN1;
            2:       return cp2u8_pkg::MODE_RAW;
            3:       return MODE_SPARE;
            4:       return cp2u8_pkg::MODE_CP1251;
            5:       return cp2u8_pkg::MODE_RAW;
            6:       return cp2u8_pkg::MODE_LATIN1;
            default: return MODE_SPARE;
        endcase
    endfunction

    // Byte modes: random byte, upper bits random half the time. Raw modes: pick a
    // sequence length first so every length shows up, now and then a full 31-bit value.
    function automatic logic [cp2u8_pkg::CP_W-1:0] random_symbol(
            input logic [cp2u8_pkg::MODE_W-1:0] mode);
        logic [31:0] upper;
        logic [31:0] value;
        if (mode == cp2u8_pkg::MODE_CP1251 || mode == cp2u8_pkg::MODE_LATIN1) begin
            upper = $urandom_range(1) ? $urandom : 32'd0;
            value = $urandom_range(255);
            return {upper[22:0], value[7:0]};
        end
        case ($urandom_range(6))
            0:       value = $urandom_range(32'h7F, 32'h0);
            1:       value = $urandom_range(32'h7FF, 32'h80);
            2:       value = $urandom_range(32'hFFFF, 32'h800);
            3:       value = $urandom_range(32'h1FFFFF, 32'h10000);
            4:       value = $urandom_range(32'h3FFFFFF, 32'h200000);
            5:       value = $urandom_range(32'h7FFFFFFF, 32'h4000000);
            default: value = $urandom;
        endcase
        return value[30:0];
    endfunction

    initial begin
        logic [cp2u8_pkg::MODE_W-1:0] mode;

        // Drive every input known from time zero, with reset asserted.
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_symbol        = '0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = cp2u8_pkg::MODE_RAW;
        sender_idle_pct = 20;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: raw mode straight out of reset, both sides of every length bound.
        send_symbol(31'h0);             // zero symbol gives a lone 0x00
        send_symbol(31'h7F);
        send_symbol(31'h80);
        send_symbol(31'h7FF);
        send_symbol(31'h800);
        send_symbol(31'hFFFF);
        send_symbol(31'h10000);
        send_symbol(31'h1FFFFF);
        send_symbol(31'h200000);
        send_symbol(31'h3FFFFFF);
        send_symbol(31'h4000000);
        send_symbol(31'h7FFFFFFF);

        // Windows-1251: ASCII edge, table ends, the unassigned 0x98 slot, junk upper bits.
        write_mode(cp2u8_pkg::MODE_CP1251);
        send_symbol(31'h0);
        send_symbol(31'h7F);
        send_symbol(31'h80);
        send_symbol(31'h98);
        send_symbol(31'hFF);
        send_symbol(31'h7FFFFF41);

        // Latin-1: top byte and ignored upper bits.
        write_mode(cp2u8_pkg::MODE_LATIN1);
        send_symbol(31'hFF);
        send_symbol(31'h7FFFFF80);
        send_symbol(31'h0);

        // Spare mode code falls back to raw.
        write_mode(MODE_SPARE);
        send_symbol(31'h7FFFFFFF);
        send_symbol(31'h41);

        // Random chunks: sender idles 20 percent, then 47, then back to back.
        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
            sender_idle_pct = (chunk < 3) ? 20 : (chunk < 6) ? 47 : 0;
            mode = chunk_mode(chunk);
            write_mode(mode);
            repeat (CHUNK_ITEMS) send_symbol(random_symbol(mode));
        end
        write_mode(cp2u8_pkg::MODE_RAW);
        drain();

        $display("Sent %0d symbols, checked %0d output bytes, %0d source mode writes.",
                 symbols_sent, bytes_checked, mode_writes);
        $display("Modes raw, 1251, Latin-1 and spare; sender idle 20%%, 47%% and none.");
        if (error_count == 0 && pending_bytes == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
